// File: rtl/vcrop_pkg.sv
// Package for the volume crop stream block: field widths, parameter defaults, register
// indexes, register reset values and the configuration register type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vcrop_pkg;

    // Fixed widths of the channel fields.
    localparam int ELEM_W   = 64;
    localparam int COORD_W  = 14;
    localparam int COUNT_W  = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = COORD_W;

    // Defaults for the top-level parameters.
    localparam int ELEM_BYTES_DEF     = 2;
    localparam int MAX_DIM_DEF        = 16384;
    localparam int MAX_COMPONENTS_DEF = 16;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_COMPONENT_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_FIRST         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_LAST          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_FIRST         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Y_LAST          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_FIRST         = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_Z_LAST          = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SWAP_BYTES      = 3'd7;

    // Register reset values.
    localparam logic [COUNT_W-1:0] RST_COMPONENT_COUNT = 5'd1;
    localparam logic [COORD_W-1:0] RST_FIRST           = 14'd0;
    localparam logic [COORD_W-1:0] RST_LAST            = 14'd16383;

    typedef struct packed {
        logic [COUNT_W-1:0] component_count;
        logic [COORD_W-1:0] x_first;
        logic [COORD_W-1:0] x_last;
        logic [COORD_W-1:0] y_first;
        logic [COORD_W-1:0] y_last;
        logic [COORD_W-1:0] z_first;
        logic [COORD_W-1:0] z_last;
        logic               swap_bytes;
    } t_cfg;

endpackage

`default_nettype wire

// File: rtl/vcrop_cfg_if.sv
// Configuration write channel of the volume crop stream block.
// Depends on vcrop_pkg for the index and data widths.
`timescale 1ns / 1ps
`default_nettype none

interface vcrop_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [vcrop_pkg::CFG_IDX_W-1:0]     index;
    logic [vcrop_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: rtl/vcrop_in_if.sv
// Input element channel of the volume crop stream block.
// Depends on vcrop_pkg for the element width.
`timescale 1ns / 1ps
`default_nettype none

interface vcrop_in_if;
    logic                            valid;
    logic                            ready;
    logic [vcrop_pkg::ELEM_W-1:0]    element_in;
    logic                            row_end;
    logic                            slice_end;
    logic                            volume_end;

    modport source (output valid, output element_in, output row_end, output slice_end,
                    output volume_end, input ready);
    modport sink   (input valid, input element_in, input row_end, input slice_end,
                    input volume_end, output ready);
endinterface

`default_nettype wire

// File: rtl/vcrop_out_if.sv
// Output element channel of the volume crop stream block.
// Depends on vcrop_pkg for the element width.
`timescale 1ns / 1ps
`default_nettype none

interface vcrop_out_if;
    logic                            valid;
    logic                            ready;
    logic [vcrop_pkg::ELEM_W-1:0]    element_out;
    logic                            cropped_row_last;
    logic                            cropped_volume_last;

    modport source (output valid, output element_out, output cropped_row_last,
                    output cropped_volume_last, input ready);
    modport sink   (input valid, input element_out, input cropped_row_last,
                    input cropped_volume_last, output ready);
endinterface

`default_nettype wire

// File: rtl/volume_crop_stream.sv
// Top level of the volume crop stream block: raster counters, window test,
// byte swap and output register.
// Depends on vcrop_pkg, vcrop_cfg_if, vcrop_in_if and vcrop_out_if.
//
//  Channel  | Direction | Payload                                         | Handshake
//  ---------+-----------+-------------------------------------------------+-----------
//  i_cfg    | in        | index, data                                     | valid/ready
//  i_in     | in        | element_in, row_end, slice_end, volume_end      | valid/ready
//  o_out    | out       | element_out, cropped_row_last, cropped_volume_last | valid/ready
//
// One input transaction is taken every cycle while i_in.ready is high; a kept element passes
// through the window stage and then the output register before it appears on o_out.
// Dropped elements produce no output transaction.
// Configuration writes are always taken.
// Reset clears the counters, empties both stages and restores the register defaults.
// A stall on o_out holds the output register and back-pressures i_in only when
// the window stage is also occupied.
`timescale 1ns / 1ps
`default_nettype none

module volume_crop_stream #(
    parameter int ELEM_BYTES     = vcrop_pkg::ELEM_BYTES_DEF,
    parameter int MAX_DIM        = vcrop_pkg::MAX_DIM_DEF,
    parameter int MAX_COMPONENTS = vcrop_pkg::MAX_COMPONENTS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    vcrop_cfg_if.sink    i_cfg,
    vcrop_in_if.sink     i_in,
    vcrop_out_if.source  o_out
);
    import vcrop_pkg::*;

    localparam int CW  = $clog2(MAX_DIM);
    localparam int PW  = (CW > COORD_W) ? CW : COORD_W;
    localparam int CIW = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int NW  = ($clog2(MAX_COMPONENTS + 1) > COUNT_W) ?
                         $clog2(MAX_COMPONENTS + 1) : COUNT_W;
    localparam int EW  = 8 * ELEM_BYTES;
    localparam logic [CW-1:0] DIM_MAX  = CW'(MAX_DIM - 1);
    localparam logic [NW-1:0] COMP_MAX = NW'(MAX_COMPONENTS);

    t_cfg r_cfg;

    logic [CIW-1:0] r_comp, n_comp;
    logic [CW-1:0]  r_col, n_col;
    logic [CW-1:0]  r_row, n_row;
    logic [CW-1:0]  r_slice, n_slice;

    logic           r_s1_valid;
    logic [EW-1:0]  r_s1_elem;
    logic           r_s1_rl;
    logic           r_s1_vl;

    logic              r_out_valid;
    logic [ELEM_W-1:0] r_out_elem;
    logic              r_out_rl;
    logic              r_out_vl;

    logic [NW-1:0] w_cnt_raw;
    logic [NW-1:0] w_cnt;
    logic          w_last_comp;
    logic          w_kept;
    logic          w_rl;
    logic          w_vl;
    logic          w_accept;
    logic          w_adv;
    logic [EW-1:0] w_swapped;

    function automatic logic [CW-1:0] f_sat_inc(input logic [CW-1:0] v);
        return (v >= DIM_MAX) ? DIM_MAX : v + CW'(1);
    endfunction

    // Configuration registers.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.component_count <= RST_COMPONENT_COUNT;
            r_cfg.x_first         <= RST_FIRST;
            r_cfg.x_last          <= RST_LAST;
            r_cfg.y_first         <= RST_FIRST;
            r_cfg.y_last          <= RST_LAST;
            r_cfg.z_first         <= RST_FIRST;
            r_cfg.z_last          <= RST_LAST;
            r_cfg.swap_bytes      <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_COMPONENT_COUNT: r_cfg.component_count <= i_cfg.data[COUNT_W-1:0];
                REG_X_FIRST:         r_cfg.x_first         <= i_cfg.data;
                REG_X_LAST:          r_cfg.x_last          <= i_cfg.data;
                REG_Y_FIRST:         r_cfg.y_first         <= i_cfg.data;
                REG_Y_LAST:          r_cfg.y_last          <= i_cfg.data;
                REG_Z_FIRST:         r_cfg.z_first         <= i_cfg.data;
                REG_Z_LAST:          r_cfg.z_last          <= i_cfg.data;
                REG_SWAP_BYTES:      r_cfg.swap_bytes      <= i_cfg.data[0];
                default: begin
                end
            endcase
        end
    end

    // Handshake: the window stage moves on whenever the output slot is free.
    assign w_adv      = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || w_adv;
    assign w_accept   = i_in.valid && i_in.ready;

    // A component count of zero behaves as one; counts above MAX_COMPONENTS are clamped to it.
    assign w_cnt_raw = NW'(r_cfg.component_count);
    always_comb begin
        if (w_cnt_raw == '0) begin
            w_cnt = NW'(1);
        end else if (w_cnt_raw > COMP_MAX) begin
            w_cnt = COMP_MAX;
        end else begin
            w_cnt = w_cnt_raw;
        end
    end
    assign w_last_comp = NW'(r_comp) >= (w_cnt - NW'(1));

    assign w_kept = (PW'(r_col)   >= PW'(r_cfg.x_first)) && (PW'(r_col)   <= PW'(r_cfg.x_last))
                 && (PW'(r_row)   >= PW'(r_cfg.y_first)) && (PW'(r_row)   <= PW'(r_cfg.y_last))
                 && (PW'(r_slice) >= PW'(r_cfg.z_first)) && (PW'(r_slice) <= PW'(r_cfg.z_last));

    assign w_rl = w_last_comp && ((PW'(r_col) == PW'(r_cfg.x_last)) || i_in.row_end);
    assign w_vl = w_rl
               && ((PW'(r_row) == PW'(r_cfg.y_last)) || i_in.slice_end || i_in.volume_end)
               && ((PW'(r_slice) == PW'(r_cfg.z_last)) || i_in.volume_end);

    // Counter advance; the strongest marker wins.
    always_comb begin
        n_comp  = r_comp;
        n_col   = r_col;
        n_row   = r_row;
        n_slice = r_slice;
        if (i_in.volume_end) begin
            n_comp  = '0;
            n_col   = '0;
            n_row   = '0;
            n_slice = '0;
        end else if (i_in.slice_end) begin
            n_comp  = '0;
            n_col   = '0;
            n_row   = '0;
            n_slice = f_sat_inc(r_slice);
        end else if (i_in.row_end) begin
            n_comp = '0;
            n_col  = '0;
            n_row  = f_sat_inc(r_row);
        end else if (w_last_comp) begin
            n_comp = '0;
            n_col  = f_sat_inc(r_col);
        end else begin
            n_comp = r_comp + CIW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_comp  <= '0;
            r_col   <= '0;
            r_row   <= '0;
            r_slice <= '0;
        end else if (w_accept) begin
            r_comp  <= n_comp;
            r_col   <= n_col;
            r_row   <= n_row;
            r_slice <= n_slice;
        end
    end

    // Window stage: only kept elements occupy it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= w_kept;
        end else if (w_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_elem <= i_in.element_in[EW-1:0];
            r_s1_rl   <= w_rl;
            r_s1_vl   <= w_vl;
        end
    end

    always_comb begin
        w_swapped = r_s1_elem;
        if (r_cfg.swap_bytes) begin
            for (int i = 0; i < ELEM_BYTES; i++) begin
                w_swapped[8*i +: 8] = r_s1_elem[8*(ELEM_BYTES-1-i) +: 8];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid) begin
            r_out_elem <= ELEM_W'(w_swapped);
            r_out_rl   <= r_s1_rl;
            r_out_vl   <= r_s1_vl;
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.element_out         = r_out_elem;
    assign o_out.cropped_row_last    = r_out_rl;
    assign o_out.cropped_volume_last = r_out_vl;

    // The end of the cropped volume is always also the end of a cropped row.
    a_vl_implies_rl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (!r_out_vl || r_out_rl))
        else $error("cropped volume end without cropped row end");

    // A volume end marker restarts every counter.
    a_volume_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.volume_end) |=>
            (r_comp == '0 && r_col == '0 && r_row == '0 && r_slice == '0))
        else $error("counters not cleared after volume end");

    // A kept element in the window stage is never lost when the output slot is free.
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_adv) |=> r_out_valid)
        else $error("kept element dropped between stages");

    // Both stages are empty straight after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_s1_valid))
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
